### design/psm_pkg.sv
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, field positions and helpers for the public suffix matcher.
// ----------------------------------------------------------------------------
package psm_pkg;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        OP_DOMAIN = 2'd0,
        OP_TEXT   = 2'd1,
        OP_NODE   = 2'd2,
        OP_CHILD  = 2'd3
    } op_t;

    // Child node types
    localparam logic [1:0] TYPE_NORMAL    = 2'd0;
    localparam logic [1:0] TYPE_EXCEPTION = 2'd1;

    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam int         BUF_DEPTH = 256;

    // Node word fields
    localparam int NODE_LEN_HI   = 5;
    localparam int NODE_OFF_LO   = 6;
    localparam int NODE_OFF_HI   = 20;
    localparam int NODE_ICANN    = 21;
    localparam int NODE_CHILD_LO = 22;
    localparam int NODE_CHILD_HI = 31;

    // Child word fields
    localparam int CH_LO_HI   = 13;
    localparam int CH_HI_LO   = 14;
    localparam int CH_HI_HI   = 27;
    localparam int CH_TYPE_LO = 28;
    localparam int CH_TYPE_HI = 29;
    localparam int CH_WILD    = 30;

    // Classified item passed from front to back
    typedef struct packed {
        op_t         op;
        logic        in_range;
        logic [14:0] addr;
        logic [31:0] word;
        logic [7:0]  dchar;
        logic        last;
    } item_t;

    // One result item
    typedef struct packed {
        logic [7:0] suffix_start;
        logic       icann;
        logic [7:0] reg_domain_start;
        logic       reg_domain_found;
        logic       too_long;
    } res_t;

    // x mod d for x < 256 * d, by eight compare-subtract steps
    function automatic logic [15:0] mod_reduce(input logic [15:0] x, input logic [15:0] d);
        logic [23:0] acc;
        logic [23:0] dk;
        acc = {8'd0, x};
        for (int k = 7; k >= 0; k--) begin
            dk = {8'd0, d} << k;
            if (acc >= dk) begin
                acc = acc - dk;
            end
        end
        return acc[15:0];
    endfunction

endpackage

### design/psm_ram.sv
// ----------------------------------------------------------------------------
// psm_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module psm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/psm_front.sv
// ----------------------------------------------------------------------------
// psm_front
// Accepts input items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module psm_front #(
    parameter int TEXT_DEPTH  = 32768,
    parameter int NODE_DEPTH  = 16384,
    parameter int CHILD_DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           operation,
    input  logic [14:0]          load_address,
    input  logic [31:0]          load_word,
    input  logic [7:0]           domain_char,
    input  logic                 domain_last,
    output logic                 item_valid,
    output psm_pkg::item_t       item,
    input  logic                 item_pop
);

    psm_pkg::item_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    psm_pkg::item_t cls;
    logic           do_push, do_pop;

    // classify: tag the item with whether its load address fits its store
    always_comb
    begin
        cls.op       = psm_pkg::op_t'(operation);
        cls.addr     = load_address;
        cls.word     = load_word;
        cls.dchar    = domain_char;
        cls.last     = domain_last;
        cls.in_range = 1'b1;
        unique case (psm_pkg::op_t'(operation))
            psm_pkg::OP_TEXT:   cls.in_range = {1'b0, load_address} < 16'(TEXT_DEPTH);
            psm_pkg::OP_NODE:   cls.in_range = {1'b0, load_address} < 16'(NODE_DEPTH);
            psm_pkg::OP_CHILD:  cls.in_range = {1'b0, load_address} < 16'(CHILD_DEPTH);
            psm_pkg::OP_DOMAIN: cls.in_range = 1'b1;
        endcase
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_pop && item_valid;

    // queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

### design/psm_back.sv
// ----------------------------------------------------------------------------
// psm_back
// Executes loads into the stores, buffers domain bytes and runs the
// right-to-left label match with binary search and byte-serial compare.
// ----------------------------------------------------------------------------
module psm_back #(
    parameter int TEXT_DEPTH  = 32768,
    parameter int NODE_DEPTH  = 16384,
    parameter int CHILD_DEPTH = 1024,
    parameter int MAX_DOMAIN  = 255
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  psm_pkg::item_t item,
    output logic           item_pop,
    input  logic           cfg_we,
    input  logic [14:0]    cfg_wdata,
    output logic           out_valid,
    input  logic           out_pop,
    output psm_pkg::res_t  res
);

    localparam int TAW = $clog2(TEXT_DEPTH);
    localparam int NAW = $clog2(NODE_DEPTH);
    localparam int CAW = $clog2(CHILD_DEPTH);
    localparam int BAW = $clog2(psm_pkg::BUF_DEPTH);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_START    = 16'h0002,
        S_SCAN     = 16'h0004,
        S_SCAN_CHK = 16'h0008,
        S_DOT      = 16'h0010,
        S_MID      = 16'h0020,
        S_NADDR    = 16'h0040,
        S_NODE     = 16'h0080,
        S_CMP      = 16'h0100,
        S_CMP_CHK  = 16'h0200,
        S_CHILD_RD = 16'h0400,
        S_CHILD    = 16'h0800,
        S_FINISH   = 16'h1000,
        S_PS_CHK   = 16'h2000,
        S_PS_RD    = 16'h4000,
        S_OUT      = 16'h8000
    } state_t;

    typedef enum logic [1:0] {
        M_LABEL = 2'd0,
        M_PS    = 2'd1,
        M_REG   = 2'd2
    } mode_t;

    state_t        state_reg, state_next;
    mode_t         mode_reg, mode_next;
    logic          out_valid_reg, out_valid_next;
    psm_pkg::res_t res_reg, res_next;
    logic [8:0]    dlen_reg, dlen_next;
    logic [14:0]   tlc_reg, tlc_next;

    logic [7:0]    len_reg, len_next;
    logic [7:0]    end_reg, end_next;
    logic [7:0]    suffix_reg, suffix_next;
    logic [7:0]    scan_reg, scan_next;
    logic [7:0]    dot_reg, dot_next;
    logic          dot_ok_reg, dot_ok_next;
    logic [7:0]    start_reg, start_next;
    logic [7:0]    llen_reg, llen_next;
    logic [7:0]    ps_reg, ps_next;
    logic [7:0]    regd_reg, regd_next;
    logic          found_reg, found_next;
    logic          icann_reg, icann_next;
    logic          wild_reg, wild_next;
    logic          too_long_reg, too_long_next;
    logic [14:0]   lo_reg, lo_next;
    logic [14:0]   hi_reg, hi_next;
    logic [14:0]   mid_reg, mid_next;
    logic [31:0]   node_reg, node_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [5:0]    n_reg, n_next;
    logic [TAW-1:0] tptr_reg, tptr_next;

    // store ports
    logic           text_we, node_we, child_we, buf_we;
    logic [7:0]     text_rd, buf_rd;
    logic [31:0]    node_rd;
    logic [30:0]    child_rd;
    logic [BAW-1:0] buf_raddr;
    logic [15:0]    node_idx, child_idx, text_off;
    logic [7:0]     start_w;
    logic [8:0]     exc_suffix;
    logic [5:0]     nlen;

    assign node_idx  = psm_pkg::mod_reduce({1'b0, mid_reg}, 16'(NODE_DEPTH));
    assign child_idx = psm_pkg::mod_reduce(
        {6'd0, node_reg[psm_pkg::NODE_CHILD_HI:psm_pkg::NODE_CHILD_LO]}, 16'(CHILD_DEPTH));
    assign text_off  = psm_pkg::mod_reduce(
        {1'b0, node_rd[psm_pkg::NODE_OFF_HI:psm_pkg::NODE_OFF_LO]}, 16'(TEXT_DEPTH));
    assign start_w    = dot_ok_reg ? (dot_reg + 8'd1) : 8'd0;
    assign exc_suffix = {1'b0, end_reg} + 9'd1;
    assign nlen       = node_reg[psm_pkg::NODE_LEN_HI:0];

    psm_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text (
        .clk(clk), .we(text_we), .waddr(item.addr[TAW-1:0]), .wdata(item.word[7:0]),
        .raddr(tptr_reg), .rdata(text_rd)
    );

    psm_ram #(.WIDTH(32), .DEPTH(NODE_DEPTH)) u_node (
        .clk(clk), .we(node_we), .waddr(item.addr[NAW-1:0]), .wdata(item.word),
        .raddr(node_idx[NAW-1:0]), .rdata(node_rd)
    );

    psm_ram #(.WIDTH(31), .DEPTH(CHILD_DEPTH)) u_child (
        .clk(clk), .we(child_we), .waddr(item.addr[CAW-1:0]), .wdata(item.word[30:0]),
        .raddr(child_idx[CAW-1:0]), .rdata(child_rd)
    );

    psm_ram #(.WIDTH(8), .DEPTH(psm_pkg::BUF_DEPTH)) u_buf (
        .clk(clk), .we(buf_we), .waddr(dlen_reg[BAW-1:0]), .wdata(item.dchar),
        .raddr(buf_raddr), .rdata(buf_rd)
    );

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // match sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        dlen_next      = dlen_reg;
        tlc_next       = tlc_reg;
        len_next       = len_reg;
        end_next       = end_reg;
        suffix_next    = suffix_reg;
        scan_next      = scan_reg;
        dot_next       = dot_reg;
        dot_ok_next    = dot_ok_reg;
        start_next     = start_reg;
        llen_next      = llen_reg;
        ps_next        = ps_reg;
        regd_next      = regd_reg;
        found_next     = found_reg;
        icann_next     = icann_reg;
        wild_next      = wild_reg;
        too_long_next  = too_long_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        node_next      = node_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        tptr_next      = tptr_reg;
        item_pop       = 1'b0;
        text_we        = 1'b0;
        node_we        = 1'b0;
        child_we       = 1'b0;
        buf_we         = 1'b0;
        buf_raddr      = '0;

        if (cfg_we)
        begin
            tlc_next = cfg_wdata;
        end
        if (out_pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    unique case (item.op)
                        psm_pkg::OP_TEXT:  text_we  = item.in_range;
                        psm_pkg::OP_NODE:  node_we  = item.in_range;
                        psm_pkg::OP_CHILD: child_we = item.in_range;
                        psm_pkg::OP_DOMAIN:
                        begin
                            if (dlen_reg <= 9'(MAX_DOMAIN))
                            begin
                                buf_we    = 1'b1;
                                dlen_next = dlen_reg + 9'd1;
                            end
                            if (item.last)
                            begin
                                state_next = S_START;
                            end
                        end
                    endcase
                end
            end
            S_START:
            begin
                too_long_next = (dlen_reg > 9'(MAX_DOMAIN));
                found_next    = 1'b0;
                regd_next     = 8'd0;
                ps_next       = 8'd0;
                icann_next    = 1'b0;
                wild_next     = 1'b0;
                len_next      = dlen_reg[7:0];
                suffix_next   = dlen_reg[7:0];
                end_next      = dlen_reg[7:0];
                scan_next     = dlen_reg[7:0];
                lo_next       = 15'd0;
                hi_next       = tlc_reg;
                mode_next     = M_LABEL;
                state_next    = (dlen_reg > 9'(MAX_DOMAIN)) ? S_OUT : S_SCAN;
            end
            // backward scan for the last dot before scan_reg
            S_SCAN:
            begin
                if (scan_reg == 8'd0)
                begin
                    dot_ok_next = 1'b0;
                    state_next  = S_DOT;
                end
                else
                begin
                    buf_raddr  = scan_reg - 8'd1;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (buf_rd == psm_pkg::DOT_CHAR)
                begin
                    dot_ok_next = 1'b1;
                    dot_next    = scan_reg - 8'd1;
                    state_next  = S_DOT;
                end
                else
                begin
                    scan_next  = scan_reg - 8'd1;
                    state_next = S_SCAN;
                end
            end
            S_DOT:
            begin
                unique case (mode_reg)
                    M_LABEL:
                    begin
                        start_next = start_w;
                        llen_next  = end_reg - start_w;
                        if (wild_reg)
                        begin
                            suffix_next = start_w;
                        end
                        state_next = S_MID;
                    end
                    M_PS:
                    begin
                        ps_next    = start_w;
                        state_next = S_PS_CHK;
                    end
                    M_REG:
                    begin
                        regd_next  = start_w;
                        found_next = 1'b1;
                        state_next = S_OUT;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            // binary search probe
            S_MID:
            begin
                if (lo_reg >= hi_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    mid_next   = lo_reg + ((hi_reg - lo_reg) >> 1);
                    state_next = S_NADDR;
                end
            end
            S_NADDR:
            begin
                state_next = S_NODE;
            end
            S_NODE:
            begin
                node_next  = node_rd;
                tptr_next  = text_off[TAW-1:0];
                cnt_next   = 6'd0;
                n_next     = ({2'b0, node_rd[psm_pkg::NODE_LEN_HI:0]} < llen_reg) ?
                             node_rd[psm_pkg::NODE_LEN_HI:0] : llen_reg[5:0];
                state_next = S_CMP;
            end
            // byte-serial label compare
            S_CMP:
            begin
                if (cnt_reg == n_reg)
                begin
                    if ({2'b0, nlen} < llen_reg)
                    begin
                        lo_next    = mid_reg + 15'd1;
                        state_next = S_MID;
                    end
                    else if ({2'b0, nlen} > llen_reg)
                    begin
                        hi_next    = mid_reg;
                        state_next = S_MID;
                    end
                    else
                    begin
                        state_next = S_CHILD_RD;
                    end
                end
                else
                begin
                    buf_raddr  = start_reg + {2'b0, cnt_reg};
                    state_next = S_CMP_CHK;
                end
            end
            S_CMP_CHK:
            begin
                if (text_rd != buf_rd)
                begin
                    // signed byte order: flip the sign bit, compare unsigned
                    if ((text_rd ^ 8'h80) < (buf_rd ^ 8'h80))
                    begin
                        lo_next = mid_reg + 15'd1;
                    end
                    else
                    begin
                        hi_next = mid_reg;
                    end
                    state_next = S_MID;
                end
                else
                begin
                    cnt_next   = cnt_reg + 6'd1;
                    tptr_next  = (tptr_reg == TAW'(TEXT_DEPTH - 1)) ? '0 : tptr_reg + 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CHILD_RD:
            begin
                icann_next = node_reg[psm_pkg::NODE_ICANN];
                state_next = S_CHILD;
            end
            // node matched: apply its child entry, then descend or finish
            S_CHILD:
            begin
                lo_next = {1'b0, child_rd[psm_pkg::CH_LO_HI:0]};
                hi_next = {1'b0, child_rd[psm_pkg::CH_HI_HI:psm_pkg::CH_HI_LO]};
                if (child_rd[psm_pkg::CH_TYPE_HI:psm_pkg::CH_TYPE_LO] == psm_pkg::TYPE_EXCEPTION)
                begin
                    suffix_next = (exc_suffix > {1'b0, len_reg}) ? len_reg : exc_suffix[7:0];
                    state_next  = S_FINISH;
                end
                else
                begin
                    if (child_rd[psm_pkg::CH_TYPE_HI:psm_pkg::CH_TYPE_LO] ==
                        psm_pkg::TYPE_NORMAL)
                    begin
                        suffix_next = start_reg;
                    end
                    wild_next = child_rd[psm_pkg::CH_WILD];
                    if (!dot_ok_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        end_next   = dot_reg;
                        scan_next  = dot_reg;
                        mode_next  = M_LABEL;
                        state_next = S_SCAN;
                    end
                end
            end
            // default rule falls back to the last label; else the suffix found is used
            S_FINISH:
            begin
                if (suffix_reg == len_reg)
                begin
                    scan_next  = len_reg;
                    mode_next  = M_PS;
                    state_next = S_SCAN;
                end
                else
                begin
                    ps_next    = suffix_reg;
                    state_next = S_PS_CHK;
                end
            end
            S_PS_CHK:
            begin
                if (ps_reg == 8'd0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    buf_raddr  = ps_reg - 8'd1;
                    state_next = S_PS_RD;
                end
            end
            S_PS_RD:
            begin
                if (buf_rd == psm_pkg::DOT_CHAR)
                begin
                    scan_next  = ps_reg - 8'd1;
                    mode_next  = M_REG;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    if (too_long_reg)
                    begin
                        res_next = '{suffix_start: 8'd0, icann: 1'b0, reg_domain_start: 8'd0,
                                     reg_domain_found: 1'b0, too_long: 1'b1};
                    end
                    else
                    begin
                        res_next = '{suffix_start: ps_reg, icann: icann_reg,
                                     reg_domain_start: regd_reg,
                                     reg_domain_found: found_reg, too_long: 1'b0};
                    end
                    dlen_next  = 9'd0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            dlen_reg      <= 9'd0;
            tlc_reg       <= 15'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            dlen_reg      <= dlen_next;
            tlc_reg       <= tlc_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        res_reg      <= res_next;
        len_reg      <= len_next;
        end_reg      <= end_next;
        suffix_reg   <= suffix_next;
        scan_reg     <= scan_next;
        dot_reg      <= dot_next;
        dot_ok_reg   <= dot_ok_next;
        start_reg    <= start_next;
        llen_reg     <= llen_next;
        ps_reg       <= ps_next;
        regd_reg     <= regd_next;
        found_reg    <= found_next;
        icann_reg    <= icann_next;
        wild_reg     <= wild_next;
        too_long_reg <= too_long_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        node_reg     <= node_next;
        cnt_reg      <= cnt_next;
        n_reg        <= n_next;
        tptr_reg     <= tptr_next;
    end

endmodule

### design/public_suffix_matcher_top.sv
// Load items and non-final domain bytes are executed in the idle state of the back end.
// A final domain byte starts the match: a backward scan of the bytes for dots,
// a binary search per label with a byte-serial compare, and a child read per matched node.
// The sequencer handles one item at a time; a 2-entry input queue and a result
// register decouple the ports. rst_n is asynchronous and clears control state;
// the stores hold nothing defined until loaded and get no clearing pass.
// ----------------------------------------------------------------------------
// public_suffix_matcher_top
// Public suffix lookup over a compressed list held in on-chip stores.
// ----------------------------------------------------------------------------
module public_suffix_matcher_top #(
    parameter int TEXT_DEPTH  = 32768,
    parameter int NODE_DEPTH  = 16384,
    parameter int CHILD_DEPTH = 1024,
    parameter int MAX_DOMAIN  = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [14:0] load_address,
    input  logic [31:0] load_word,
    input  logic [7:0]  domain_char,
    input  logic        domain_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  suffix_start,
    output logic        icann,
    output logic [7:0]  reg_domain_start,
    output logic        reg_domain_found,
    output logic        too_long,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata
);

    logic           item_valid;
    logic           item_pop;
    psm_pkg::item_t item;
    logic           out_valid;
    psm_pkg::res_t  res;

    psm_front #(
        .TEXT_DEPTH(TEXT_DEPTH), .NODE_DEPTH(NODE_DEPTH), .CHILD_DEPTH(CHILD_DEPTH)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .operation(operation), .load_address(load_address), .load_word(load_word),
        .domain_char(domain_char), .domain_last(domain_last),
        .item_valid(item_valid), .item(item), .item_pop(item_pop)
    );

    psm_back #(
        .TEXT_DEPTH(TEXT_DEPTH), .NODE_DEPTH(NODE_DEPTH), .CHILD_DEPTH(CHILD_DEPTH),
        .MAX_DOMAIN(MAX_DOMAIN)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .item_valid(item_valid), .item(item),
        .item_pop(item_pop), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .out_valid(out_valid), .out_pop(pop), .res(res)
    );

    assign empty            = !out_valid;
    assign suffix_start     = res.suffix_start;
    assign icann            = res.icann;
    assign reg_domain_start = res.reg_domain_start;
    assign reg_domain_found = res.reg_domain_found;
    assign too_long         = res.too_long;

    // an overlong domain reports nothing else
    a_too_long_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && too_long) |-> (suffix_start == 8'd0 && !icann &&
                                  reg_domain_start == 8'd0 && !reg_domain_found))
        else $error("too_long result carries nonzero fields");

    // no registrable domain means a zero offset
    a_reg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !reg_domain_found) |-> (reg_domain_start == 8'd0))
        else $error("registrable offset set without found flag");

    // the registrable domain starts strictly left of the suffix
    a_reg_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && reg_domain_found) |-> (reg_domain_start < suffix_start))
        else $error("registrable domain does not precede suffix");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Public suffix matcher testbench
// Fills the low part of the text, node and child stores with a sorted
// two-letter list, then sends directed and random domains (walked down the
// loaded tree, plus noise) with loads interleaved. Every loaded word points
// only into the filled part, so the block never reads an unwritten entry.
// A predictor in the testbench computes each result, and a checker compares
// every popped result field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TEXT_SIZE  = 32768;
    localparam int NODE_SIZE  = 16384;
    localparam int CHILD_SIZE = 1024;
    localparam int DOMAIN_MAX = 255;
    localparam int SORTED_N   = 52;
    localparam int KID_N      = 16;
    localparam int IDLE_LIMIT = 200000;
    localparam int SETTLE     = 20;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  operation;
    logic [14:0] load_address;
    logic [31:0] load_word;
    logic [7:0]  domain_char;
    logic        domain_last;
    logic        empty;
    logic        pop;
    logic [7:0]  suffix_start;
    logic        icann;
    logic [7:0]  reg_domain_start;
    logic        reg_domain_found;
    logic        too_long;
    logic        cfg_we;
    logic [14:0] cfg_wdata;

    public_suffix_matcher_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .operation        (operation),
        .load_address     (load_address),
        .load_word        (load_word),
        .domain_char      (domain_char),
        .domain_last      (domain_last),
        .empty            (empty),
        .pop              (pop),
        .suffix_start     (suffix_start),
        .icann            (icann),
        .reg_domain_start (reg_domain_start),
        .reg_domain_found (reg_domain_found),
        .too_long         (too_long),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata)
    );

    // Predictor state: mirror of the stores and the register
    logic [7:0]  lbl_text [TEXT_SIZE];
    logic [31:0] node_mem [NODE_SIZE];
    logic [30:0] kid_mem  [CHILD_SIZE];
    logic [7:0]  dom_buf  [256];
    int          dom_len;
    int          top_count;

    psm_pkg::res_t lookup_q [$];
    logic [7:0]    dom_q [$];
    int            errors;
    bit            no_gaps;
    int            hold_cnt;

    // Clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] letter(int v);
        return 8'h61 + 8'(v % 26);
    endfunction

    // Signed byte compare of a node label with domain bytes
    function automatic int cmp_label(logic [31:0] nd, int st, int llen);
        int nlen;
        int off;
        int n;
        logic signed [7:0] a;
        logic signed [7:0] b;
        nlen = nd[5:0];
        off  = nd[20:6];
        n    = (nlen < llen) ? nlen : llen;
        for (int i = 0; i < n; i++)
        begin
            a = lbl_text[(off + i) % TEXT_SIZE];
            b = dom_buf[(st + i) & 255];
            if (a != b) return (a < b) ? -1 : 1;
        end
        if (nlen < llen) return -1;
        if (nlen > llen) return 1;
        return 0;
    endfunction

    function automatic bit search_nodes(int lo, int hi, int st, int llen, output int idx);
        int mid;
        int r;
        idx = 0;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            r = cmp_label(node_mem[mid % NODE_SIZE], st, llen);
            if (r < 0) lo = mid + 1;
            else if (r == 0)
            begin
                idx = mid % NODE_SIZE;
                return 1'b1;
            end
            else hi = mid;
        end
        return 1'b0;
    endfunction

    function automatic int find_dot(int stop);
        for (int i = stop - 1; i >= 0; i--)
            if (dom_buf[i & 255] == psm_pkg::DOT_CHAR) return i;
        return -1;
    endfunction

    // Right-to-left label walk down the suffix tree
    function automatic psm_pkg::res_t match_domain();
        psm_pkg::res_t r;
        int            len, sfx, stop, lo, hi, dot, st, f, ps, rg;
        logic          ic, fnd, wild;
        logic [31:0]   nd;
        logic [30:0]   ch;
        len = dom_len; sfx = len; stop = len; lo = 0; hi = top_count;
        ic = 1'b0; rg = 0; fnd = 1'b0; wild = 1'b0;
        forever
        begin
            dot = find_dot(stop);
            st  = dot + 1;
            if (wild) sfx = st;
            if (lo == hi) break;
            if (!search_nodes(lo, hi, st, stop - st, f)) break;
            nd   = node_mem[f];
            ic   = nd[psm_pkg::NODE_ICANN];
            ch   = kid_mem[nd[psm_pkg::NODE_CHILD_HI:psm_pkg::NODE_CHILD_LO]];
            lo   = ch[psm_pkg::CH_LO_HI:0];
            hi   = ch[psm_pkg::CH_HI_HI:psm_pkg::CH_HI_LO];
            if (ch[psm_pkg::CH_TYPE_HI:psm_pkg::CH_TYPE_LO] == psm_pkg::TYPE_NORMAL)
                sfx = st;
            else if (ch[psm_pkg::CH_TYPE_HI:psm_pkg::CH_TYPE_LO] == psm_pkg::TYPE_EXCEPTION)
            begin
                sfx = (stop + 1 > len) ? len : stop + 1;
                break;
            end
            wild = ch[psm_pkg::CH_WILD];
            if (dot < 0) break;
            stop = dot;
        end
        ps = (sfx == len) ? find_dot(len) + 1 : sfx;
        if (ps > 0 && dom_buf[(ps - 1) & 255] == psm_pkg::DOT_CHAR)
        begin
            rg  = find_dot(ps - 1) + 1;
            fnd = 1'b1;
        end
        r.suffix_start     = 8'(ps);
        r.icann            = ic;
        r.reg_domain_start = 8'(rg);
        r.reg_domain_found = fnd;
        r.too_long         = 1'b0;
        return r;
    endfunction

    // Apply one accepted item to the predictor
    function automatic void predict_item(psm_pkg::op_t op, logic [14:0] addr,
                                         logic [31:0] word, logic [7:0] ch, logic last);
        psm_pkg::res_t r;
        case (op)
            psm_pkg::OP_TEXT:  lbl_text[addr] = word[7:0];
            psm_pkg::OP_NODE:  if (addr < NODE_SIZE) node_mem[addr] = word;
            psm_pkg::OP_CHILD: if (addr < CHILD_SIZE) kid_mem[addr] = word[30:0];
            default:
            begin
                if (dom_len <= DOMAIN_MAX)
                begin
                    dom_buf[dom_len & 255] = ch;
                    dom_len++;
                end
                if (last)
                begin
                    if (dom_len > DOMAIN_MAX)
                        r = '{too_long: 1'b1, default: '0};
                    else
                        r = match_domain();
                    lookup_q.push_back(r);
                    dom_len = 0;
                end
            end
        endcase
    endfunction

    // Send one item; returns at the edge where it is accepted
    task automatic send_item(psm_pkg::op_t op, logic [14:0] addr, logic [31:0] word,
                             logic [7:0] ch, logic last);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        operation    <= op;
        load_address <= addr;
        load_word    <= word;
        domain_char  <= ch;
        domain_last  <= last;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_item(op, addr, word, ch, last);
    endtask

    task automatic send_load(psm_pkg::op_t op, logic [14:0] addr, logic [31:0] word);
        send_item(op, addr, word, 8'($urandom), 1'($urandom));
    endtask

    // Send dom_q as one domain, optionally with loads between its bytes
    task automatic send_domain(bit mix_loads);
        int n;
        n = dom_q.size();
        for (int i = 0; i < n; i++)
        begin
            if (mix_loads && $urandom_range(0, 9) == 0) random_load();
            send_item(psm_pkg::OP_DOMAIN, 15'($urandom), $urandom, dom_q[i], i == n - 1);
        end
    endtask

    task automatic send_text(string s);
        dom_q.delete();
        for (int i = 0; i < s.len(); i++) dom_q.push_back(s[i]);
        send_domain(1'b0);
    endtask

    // Wait until every expected result has been popped
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (lookup_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_top_count(int v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= 15'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        top_count = v;
    endtask

    function automatic logic [31:0] make_child();
        int lo, hi, r;
        lo = $urandom_range(0, SORTED_N - 20);
        hi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SORTED_N) :
             lo + $urandom_range(1, 16);
        r  = $urandom_range(0, 9);
        return {1'($urandom), 1'($urandom_range(0, 4) == 0),
                2'(r < 6 ? 0 : r - 6), 14'(hi), 14'(lo)};
    endfunction

    function automatic logic [31:0] make_node(int i);
        return {10'($urandom_range(0, KID_N - 1)), 1'($urandom), 15'(2 * i), 6'd2};
    endfunction

    // Random load; node and child words point only into the filled entries
    task automatic random_load();
        int sel;
        sel = $urandom_range(0, 2);
        if (sel == 0)
            send_load(psm_pkg::OP_TEXT, 15'($urandom), {24'($urandom), letter($urandom)});
        else if (sel == 1)
            send_load(psm_pkg::OP_NODE, 15'($urandom),
                      make_node($urandom_range(0, SORTED_N - 1)));
        else
            send_load(psm_pkg::OP_CHILD, ($urandom_range(0, 4) == 0) ? 15'($urandom)
                                                                     : 15'($urandom_range(0, 1023)),
                      make_child());
    endtask

    // Build a domain in dom_q, mostly by walking the predictor's tree
    task automatic build_domain();
        int          levels, lo, hi, k, n;
        logic [31:0] nd;
        logic [30:0] ch;
        logic [7:0]  lab [$];
        dom_q.delete();
        if ($urandom_range(0, 79) == 0)
        begin
            n = $urandom_range(240, 300);
            for (int i = 0; i < n; i++)
                dom_q.push_back(($urandom_range(0, 5) == 0) ? psm_pkg::DOT_CHAR
                                                            : letter($urandom));
            return;
        end
        levels = $urandom_range(1, 5);
        lo = 0;
        hi = (top_count < SORTED_N) ? top_count : SORTED_N;
        for (int l = 0; l < levels; l++)
        begin
            lab.delete();
            if (lo < hi && $urandom_range(0, 99) < 85)
            begin
                k  = $urandom_range(lo, hi - 1) % NODE_SIZE;
                nd = node_mem[k];
                for (int i = 0; i < nd[5:0]; i++)
                    lab.push_back(lbl_text[(nd[20:6] + i) % TEXT_SIZE]);
                ch = kid_mem[nd[psm_pkg::NODE_CHILD_HI:psm_pkg::NODE_CHILD_LO]];
                lo = ch[psm_pkg::CH_LO_HI:0];
                hi = ch[psm_pkg::CH_HI_HI:psm_pkg::CH_HI_LO];
            end
            else
            begin
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                    lab.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : letter($urandom));
                lo = 0;
                hi = 0;
            end
            if (l > 0) dom_q.push_front(psm_pkg::DOT_CHAR);
            for (int i = lab.size() - 1; i >= 0; i--) dom_q.push_front(lab[i]);
        end
        if (dom_q.size() == 0) dom_q.push_back(letter($urandom));
    endtask

    // Load a sorted two-letter list into the low store entries
    task automatic test_fill_stores();
        no_gaps = 1'b1;
        for (int i = 0; i < SORTED_N; i++)
        begin
            send_load(psm_pkg::OP_TEXT, 15'(2 * i), {24'($urandom), letter(i / 26)});
            send_load(psm_pkg::OP_TEXT, 15'(2 * i + 1), {24'($urandom), letter(i)});
        end
        for (int i = 0; i < SORTED_N; i++) send_load(psm_pkg::OP_NODE, 15'(i), make_node(i));
        for (int i = 0; i < KID_N; i++) send_load(psm_pkg::OP_CHILD, 15'(i), make_child());
        no_gaps = 1'b0;
    endtask

    // Hand-built corner cases on nodes aa, ab, ac, ad
    task automatic test_directed();
        set_top_count(SORTED_N);
        send_load(psm_pkg::OP_NODE, 15'd0, {10'd0, 1'b1, 15'd0, 6'd2});
        send_load(psm_pkg::OP_NODE, 15'd1, {10'd1, 1'b0, 15'd2, 6'd2});
        send_load(psm_pkg::OP_NODE, 15'd2, {10'd2, 1'b1, 15'd4, 6'd2});
        send_load(psm_pkg::OP_NODE, 15'd3, {10'd3, 1'b1, 15'd6, 6'd2});
        // exception child, parent-only type three, empty range, wildcard
        send_load(psm_pkg::OP_CHILD, 15'd0, {2'b00, psm_pkg::TYPE_EXCEPTION, 14'd10, 14'd0});
        send_load(psm_pkg::OP_CHILD, 15'd1, {2'b00, 2'd3, 14'd10, 14'd0});
        send_load(psm_pkg::OP_CHILD, 15'd2, {2'b00, psm_pkg::TYPE_NORMAL, 14'd3, 14'd5});
        send_load(psm_pkg::OP_CHILD, 15'd3, {2'b01, psm_pkg::TYPE_NORMAL, 14'd0, 14'd0});
        // loads out of range are dropped
        send_load(psm_pkg::OP_NODE, 15'h7FFF, 32'hFFFF_FFFF);
        send_load(psm_pkg::OP_CHILD, 15'd1024, 32'h0);
        send_text("aa");
        send_text("x.ab");
        send_text("y.ac");
        send_text("p.q.ad");
        send_text(".");
        send_text("zz.");
        dom_q.delete();
        dom_q = '{8'h00, psm_pkg::DOT_CHAR, 8'h80, 8'hFF, psm_pkg::DOT_CHAR, 8'h7F};
        send_domain(1'b1);
        dom_q.delete();
        for (int i = 0; i < 260; i++)
            dom_q.push_back((i % 4 == 3) ? psm_pkg::DOT_CHAR : 8'h61);
        send_domain(1'b0);
        set_top_count(0);
        send_text("m.aa");
        set_top_count(SORTED_N);
        send_text("k.ab");
    endtask

    task automatic test_random(int items);
        int sent;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                random_load();
                sent++;
            end
            else
            begin
                build_domain();
                sent += dom_q.size();
                send_domain(1'b1);
            end
        end
    endtask

    task automatic test_config_sweep();
        int vals [5];
        vals = '{SORTED_N, 2, 0, 1, 0};
        vals[4] = $urandom_range(2, SORTED_N);
        foreach (vals[i])
        begin
            set_top_count(vals[i]);
            test_random(50);
        end
        set_top_count(SORTED_N);
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        hold_cnt = 400;
        no_gaps  = 1'b1;
        for (int i = 0; i < 10; i++)
        begin
            build_domain();
            send_domain(1'b0);
        end
        no_gaps = 1'b0;
        drain();
    endtask

    // Result checker
    always @(posedge clk)
    begin
        psm_pkg::res_t e;
        if (rst_n && pop && !empty)
        begin
            if (lookup_q.size() == 0)
            begin
                $display("%0t: unexpected result suffix_start %0d", $time, suffix_start);
                errors++;
            end
            else
            begin
                e = lookup_q.pop_front();
                if (suffix_start !== e.suffix_start)
                begin
                    $display("%0t: suffix_start expected %0d actual %0d",
                             $time, e.suffix_start, suffix_start);
                    errors++;
                end
                if (icann !== e.icann)
                begin
                    $display("%0t: icann expected %0d actual %0d", $time, e.icann, icann);
                    errors++;
                end
                if (reg_domain_start !== e.reg_domain_start)
                begin
                    $display("%0t: reg_domain_start expected %0d actual %0d",
                             $time, e.reg_domain_start, reg_domain_start);
                    errors++;
                end
                if (reg_domain_found !== e.reg_domain_found)
                begin
                    $display("%0t: reg_domain_found expected %0d actual %0d",
                             $time, e.reg_domain_found, reg_domain_found);
                    errors++;
                end
                if (too_long !== e.too_long)
                begin
                    $display("%0t: too_long expected %0d actual %0d", $time, e.too_long, too_long);
                    errors++;
                end
            end
        end
    end

    // Receiver: random pop gaps plus requested hold-offs
    initial begin
        int gap;
        gap = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                pop <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                gap = pick_gap();
            end
        end
    end

    // Watchdog on cycles with no accepted item
    initial begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        errors   = 0;
        hold_cnt = 0;
        no_gaps  = 1'b0;
        dom_len  = 0;
        top_count = 0;
        rst_n        <= 1'b0;
        push         <= 1'b0;
        pop          <= 1'b0;
        operation    <= psm_pkg::OP_DOMAIN;
        load_address <= '0;
        load_word    <= '0;
        domain_char  <= '0;
        domain_last  <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_stores();
        test_directed();
        test_backpressure();
        test_config_sweep();
        drain();
        repeat (50) @(posedge clk);
        if (lookup_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, lookup_q.size());
            errors++;
        end
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
